/* sv/psxp_pkg.sv */
// Shared types, command codes and lookup functions for the gamepad poll sequencer.
package psxp_pkg;

    localparam int unsigned HEADER_LEN = 3;
    localparam int unsigned CMD_COUNT  = 6;
    localparam int unsigned TABLE_PARAMS = 8;

    localparam logic [7:0] HDR_SYNC_BYTE = 8'h01;
    localparam logic [7:0] HDR_IDLE_BYTE = 8'h00;

    localparam logic [2:0] CMD_POLL      = 3'd0;
    localparam logic [2:0] CMD_ENTER_CFG = 3'd1;
    localparam logic [2:0] CMD_EXIT_CFG  = 3'd2;
    localparam logic [2:0] CMD_ANALOG    = 3'd3;
    localparam logic [2:0] CMD_PRESSURE  = 3'd4;
    localparam logic [2:0] CMD_VIBRATE   = 3'd5;

    localparam logic MODE_START    = 1'b0;
    localparam logic MODE_EXCHANGE = 1'b1;

    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_PACKET = 1'b1;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // Store write port: address is sized for the largest store.
    typedef struct packed {
        logic       en;
        logic [5:0] addr;
        logic [7:0] data;
    } t_store_wr;

    typedef struct packed {
        logic       en;
        logic [5:0] addr;
    } t_store_rd;

    function automatic logic [7:0] psxp_flip8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7 - i] = v[i];
        end
        return r;
    endfunction

    function automatic logic [7:0] psxp_cmd_byte(input logic [2:0] cmd);
        logic [7:0] b;
        unique case (cmd)
            CMD_POLL:      b = 8'h42;
            CMD_ENTER_CFG: b = 8'h43;
            CMD_EXIT_CFG:  b = 8'h43;
            CMD_ANALOG:    b = 8'h44;
            CMD_PRESSURE:  b = 8'h4F;
            CMD_VIBRATE:   b = 8'h4D;
            default:       b = 8'h00;
        endcase
        return b;
    endfunction

    // Parameter bytes of each command, position 0 in the low byte.
    function automatic logic [7:0] psxp_param_byte(input logic [2:0] cmd,
                                                   input logic [2:0] pos);
        logic [63:0] row;
        unique case (cmd)
            CMD_POLL:      row = 64'h0000_0000_0000_0000;
            CMD_ENTER_CFG: row = 64'h0000_0000_0000_0001;
            CMD_EXIT_CFG:  row = 64'h0000_5A5A_5A5A_5A00;
            CMD_ANALOG:    row = 64'h0000_0000_0000_0301;
            CMD_PRESSURE:  row = 64'h0000_0000_0003_FFFF;
            CMD_VIBRATE:   row = 64'h0000_FFFF_FFFF_0100;
            default:       row = 64'h0000_0000_0000_0000;
        endcase
        return row[{pos, 3'b000} +: 8];
    endfunction

endpackage

/* sv/psxp_store.sv */
// Packet store: one write port, one registered read port.
module psxp_store #(
    parameter int DEPTH = 33
) (
    input  logic                i_clk,
    input  psxp_pkg::t_store_wr i_wr,
    input  psxp_pkg::t_store_rd i_rd,
    output logic [7:0]          o_rd_data
);
    import psxp_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr[AW-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/psx_pad_poll_sequencer_unit.sv */
// Top level of the gamepad poll sequencer: link byte sequencing and packet readout.
//
//  Channel   Direction  Handshake               Payload
//  --------  ---------  ----------------------  ------------------------------------------
//  in        sink       i_in_valid / o_in_stall  i_mode, i_command_index, i_rx_byte
//  out       source     o_out_valid / i_out_stall o_kind, o_tx_byte, o_select_active,
//                                                o_packet_byte, o_packet_index, o_last,
//                                                o_status
//
// Flow: a start or exchange transaction that yields one result is taken and
//   its result sits in the output register; the next input is taken as soon as that
//   register is free. The final exchange of a poll triggers a readout of N results
//   (N = 3 header bytes + data bytes, at most 33), one store read per cycle while the
//   output is not stalled, through the single registered read port; the input stalls meanwhile.
// Reset: i_rst_n is synchronous, active low; it clears the sequencer, the busy flag and the
//   output valid. Store contents are not cleared: only entries written in the running
//   poll are read back.
// Stalls: i_out_stall holds the output register and backs up the readout; the input
//   stalls while the output register is full and stalled, or while a readout runs.
module psx_pad_poll_sequencer_unit #(
    parameter int PARAM_LEN = 6,
    parameter int DATA_MAX  = 30
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_mode,
    input  logic [2:0] i_command_index,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_kind,
    output logic [7:0] o_tx_byte,
    output logic       o_select_active,
    output logic [7:0] o_packet_byte,
    output logic [5:0] o_packet_index,
    output logic       o_last,
    output logic       o_status
);
    import psxp_pkg::*;

    localparam int         STORE_DEPTH = HEADER_LEN + DATA_MAX;
    localparam logic [4:0] DATA_MAX_W  = 5'(DATA_MAX);
    localparam logic [5:0] HDR_LEN_W   = 6'(HEADER_LEN);

    typedef enum logic {S_READY, S_DUMP} t_state;

    // Sequencer state
    t_state     r_state, n_state;
    logic       r_busy, n_busy;
    logic [2:0] r_active_cmd, n_active_cmd;
    logic [5:0] r_byte_count, n_byte_count;
    logic [4:0] r_data_count, n_data_count;
    logic [4:0] r_need, n_need;
    logic [5:0] r_issue_idx, n_issue_idx;
    logic       r_rd_valid, n_rd_valid;
    logic [5:0] r_rd_idx, n_rd_idx;

    // Output register
    logic       r_out_valid, n_out_valid;
    logic       r_o_kind, n_o_kind;
    logic [7:0] r_o_tx, n_o_tx;
    logic       r_o_sel, n_o_sel;
    logic [7:0] r_o_pb, n_o_pb;
    logic [5:0] r_o_pi, n_o_pi;
    logic       r_o_last, n_o_last;
    logic       r_o_status, n_o_status;

    logic       out_free;
    logic       in_acc;
    logic       issue;
    logic       load_out;
    logic [7:0] flip_rx;
    logic [5:0] bc_next;
    logic [4:0] dc_next;
    logic [4:0] need_raw;
    logic [4:0] need_sat;
    logic [7:0] param_raw;
    logic [7:0] w_rd_data;
    t_store_wr  store_wr;
    t_store_rd  store_rd;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_READY) || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign flip_rx  = psxp_flip8(i_rx_byte);
    assign bc_next  = r_byte_count + 6'd1;
    assign dc_next  = (r_byte_count >= HDR_LEN_W) ? r_data_count + 5'd1 : r_data_count;
    // Mode byte low nibble times two gives the data length; clamp it to DATA_MAX.
    assign need_raw = {flip_rx[3:0], 1'b0};
    assign need_sat = (need_raw > DATA_MAX_W) ? DATA_MAX_W : need_raw;

    // Past the table or the command's parameter count, send zeros.
    assign param_raw = (int'(dc_next) < PARAM_LEN && int'(dc_next) < int'(TABLE_PARAMS))
                     ? psxp_param_byte(r_active_cmd, dc_next[2:0]) : 8'h00;

    // Readout: keep one store read in flight ahead of the output register.
    assign load_out = r_rd_valid && out_free;
    assign issue    = (r_state == S_DUMP) && (r_issue_idx < r_byte_count)
                   && (!r_rd_valid || load_out);

    assign store_wr.en   = in_acc && (i_mode == MODE_EXCHANGE) && r_busy;
    assign store_wr.addr = r_byte_count;
    assign store_wr.data = flip_rx;
    assign store_rd.en   = issue;
    assign store_rd.addr = r_issue_idx;

    psxp_store #(
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr     (store_wr),
        .i_rd     (store_rd),
        .o_rd_data(w_rd_data)
    );

    always_comb begin
        n_state      = r_state;
        n_busy       = r_busy;
        n_active_cmd = r_active_cmd;
        n_byte_count = r_byte_count;
        n_data_count = r_data_count;
        n_need       = r_need;
        n_issue_idx  = r_issue_idx;
        n_rd_valid   = r_rd_valid;
        n_rd_idx     = r_rd_idx;
        n_out_valid  = r_out_valid && i_out_stall;
        n_o_kind     = r_o_kind;
        n_o_tx       = r_o_tx;
        n_o_sel      = r_o_sel;
        n_o_pb       = r_o_pb;
        n_o_pi       = r_o_pi;
        n_o_last     = r_o_last;
        n_o_status   = r_o_status;

        if (in_acc) begin
            // Every single-result transaction: default to a rejected transmit result.
            n_out_valid = 1'b1;
            n_o_kind    = KIND_TX;
            n_o_tx      = 8'h00;
            n_o_sel     = 1'b0;
            n_o_pb      = 8'h00;
            n_o_pi      = 6'd0;
            n_o_last    = 1'b1;
            n_o_status  = STATUS_REJECT;
            if (i_mode == MODE_START) begin
                if (r_busy) begin
                    n_o_sel = 1'b1;
                end else if (int'(i_command_index) < int'(CMD_COUNT)) begin
                    n_active_cmd = i_command_index;
                    n_byte_count = 6'd0;
                    n_data_count = 5'd0;
                    n_busy       = 1'b1;
                    n_o_tx       = psxp_flip8(HDR_SYNC_BYTE);
                    n_o_sel      = 1'b1;
                    n_o_status   = STATUS_OK;
                end
            end else if (r_busy) begin
                n_byte_count = bc_next;
                n_data_count = dc_next;
                if (r_byte_count == 6'd1) begin
                    n_need = need_sat;
                end
                if (bc_next < HDR_LEN_W) begin
                    n_o_tx     = psxp_flip8((bc_next == 6'd1) ? psxp_cmd_byte(r_active_cmd)
                                                              : HDR_IDLE_BYTE);
                    n_o_sel    = 1'b1;
                    n_o_status = STATUS_OK;
                end else if (dc_next < r_need) begin
                    n_o_tx     = psxp_flip8(param_raw);
                    n_o_sel    = 1'b1;
                    n_o_status = STATUS_OK;
                end else begin
                    // Packet complete: release select and start the readout.
                    n_out_valid = 1'b0;
                    n_busy      = 1'b0;
                    n_state     = S_DUMP;
                    n_issue_idx = 6'd0;
                    n_rd_valid  = 1'b0;
                end
            end
        end

        if (load_out) begin
            n_out_valid = 1'b1;
            n_o_kind    = KIND_PACKET;
            n_o_tx      = 8'h00;
            n_o_sel     = 1'b0;
            n_o_pb      = w_rd_data;
            n_o_pi      = r_rd_idx;
            n_o_last    = (r_rd_idx + 6'd1 == r_byte_count);
            n_o_status  = STATUS_OK;
            n_rd_valid  = 1'b0;
            if (r_rd_idx + 6'd1 == r_byte_count) begin
                n_state = S_READY;
            end
        end

        if (issue) begin
            n_rd_valid  = 1'b1;
            n_rd_idx    = r_issue_idx;
            n_issue_idx = r_issue_idx + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_READY;
            r_busy       <= 1'b0;
            r_active_cmd <= CMD_POLL;
            r_byte_count <= 6'd0;
            r_data_count <= 5'd0;
            r_need       <= 5'd0;
            r_issue_idx  <= 6'd0;
            r_rd_valid   <= 1'b0;
            r_rd_idx     <= 6'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_busy       <= n_busy;
            r_active_cmd <= n_active_cmd;
            r_byte_count <= n_byte_count;
            r_data_count <= n_data_count;
            r_need       <= n_need;
            r_issue_idx  <= n_issue_idx;
            r_rd_valid   <= n_rd_valid;
            r_rd_idx     <= n_rd_idx;
            r_out_valid  <= n_out_valid;
        end
        r_o_kind   <= n_o_kind;
        r_o_tx     <= n_o_tx;
        r_o_sel    <= n_o_sel;
        r_o_pb     <= n_o_pb;
        r_o_pi     <= n_o_pi;
        r_o_last   <= n_o_last;
        r_o_status <= n_o_status;
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_o_kind;
    assign o_tx_byte       = r_o_tx;
    assign o_select_active = r_o_sel;
    assign o_packet_byte   = r_o_pb;
    assign o_packet_index  = r_o_pi;
    assign o_last          = r_o_last;
    assign o_status        = r_o_status;

    // Packet readout results never carry select or a reject.
    a_packet_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_PACKET) |-> !o_select_active && !o_status)
        else $error("packet readout result with select or reject");

    // No transaction is taken while the readout runs.
    a_dump_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> o_in_stall)
        else $error("input taken during readout");

    // Taking the final packet byte leaves the sequencer ready for input; a new start may
    // already be taken in that same cycle.
    a_dump_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && (o_kind == KIND_PACKET) && o_last
        |=> (r_state == S_READY))
        else $error("readout did not return to idle");

    // While a poll runs past the header, data still remains to be exchanged.
    a_data_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && (r_byte_count >= HDR_LEN_W) |-> (r_data_count < r_need))
        else $error("busy with no data left to exchange");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the gamepad poll sequencer: directed rows, random polls, stalls.
`timescale 1ns / 1ps

module testbench;
    import psxp_pkg::*;

    // Match the block's defaults; the instance below passes them explicitly.
    localparam int PAD_PARAM_LEN = 6;
    localparam int PAD_DATA_MAX  = 30;
    localparam int STORE_DEPTH   = 33;

    // Command indexes past the table; the block must reject both.
    localparam logic [2:0] CMD_BAD_6 = 3'd6;
    localparam logic [2:0] CMD_BAD_7 = 3'd7;

    // Drain allowance after the last expected result: longer than a full readout.
    localparam int DRAIN_CYCLES = 48;
    // Receiver hold-off for the back-pressure stretch.
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS = 78;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       select_active;
        logic [7:0] packet_byte;
        logic [5:0] packet_index;
        logic       last;
        logic       status;
    } poll_result_t;

    typedef struct packed {
        logic         mode;
        logic [2:0]   cmd;
        logic [7:0]   rx;
        logic         typed;
        poll_result_t want;
    } stim_row_t;

    // Results that can be read straight off the protocol description.
    localparam poll_result_t REJECT_IDLE =
        '{KIND_TX, 8'h00, 1'b0, 8'h00, 6'd0, 1'b1, STATUS_REJECT};
    localparam poll_result_t REJECT_BUSY =
        '{KIND_TX, 8'h00, 1'b1, 8'h00, 6'd0, 1'b1, STATUS_REJECT};
    // Start accepted: the sync byte 0x01 goes out bit-reversed.
    localparam poll_result_t START_OK =
        '{KIND_TX, 8'h80, 1'b1, 8'h00, 6'd0, 1'b1, STATUS_OK};
    localparam poll_result_t NOT_TYPED = '0;

    localparam logic [7:0] PAD_CMD_BYTES [6] = '{8'h42, 8'h43, 8'h43, 8'h44, 8'h4F, 8'h4D};
    localparam logic [7:0] PAD_PARAMS [6][8] = '{
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h00, 8'h00},
        '{8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hFF, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00}
    };

    // Directed part. Exchange rows ignore cmd; rx of the second exchange of a poll
    // carries the mode byte, whose reversed low nibble sets the data length.
    localparam int DIRECTED_N = 22;
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_N] = '{
        '{MODE_EXCHANGE, CMD_POLL,      8'hFF, 1'b1, REJECT_IDLE},  // exchange while idle
        '{MODE_START,    CMD_BAD_7,     8'h00, 1'b1, REJECT_IDLE},  // bad command
        '{MODE_START,    CMD_BAD_6,     8'h00, 1'b1, REJECT_IDLE},
        '{MODE_START,    CMD_POLL,      8'h00, 1'b1, START_OK},
        '{MODE_START,    CMD_VIBRATE,   8'h00, 1'b1, REJECT_BUSY},  // start while busy
        '{MODE_EXCHANGE, CMD_POLL,      8'hFF, 1'b0, NOT_TYPED},
        '{MODE_EXCHANGE, CMD_POLL,      8'h0F, 1'b0, NOT_TYPED},    // no data bytes
        '{MODE_EXCHANGE, CMD_POLL,      8'h5A, 1'b0, NOT_TYPED},    // readout of header
        '{MODE_START,    CMD_ENTER_CFG, 8'h00, 1'b1, START_OK},
        '{MODE_EXCHANGE, CMD_POLL,      8'h00, 1'b0, NOT_TYPED},
        '{MODE_EXCHANGE, CMD_POLL,      8'h80, 1'b0, NOT_TYPED},    // two data bytes
        '{MODE_EXCHANGE, CMD_POLL,      8'hA5, 1'b0, NOT_TYPED},
        '{MODE_EXCHANGE, CMD_POLL,      8'h3C, 1'b0, NOT_TYPED},
        '{MODE_EXCHANGE, CMD_POLL,      8'hC3, 1'b0, NOT_TYPED},
        '{MODE_START,    CMD_PRESSURE,  8'h00, 1'b1, START_OK},
        '{MODE_EXCHANGE, CMD_POLL,      8'h00, 1'b0, NOT_TYPED},
        '{MODE_EXCHANGE, CMD_POLL,      8'h40, 1'b0, NOT_TYPED},    // four data bytes
        '{MODE_EXCHANGE, CMD_POLL,      8'hFF, 1'b0, NOT_TYPED},
        '{MODE_EXCHANGE, CMD_POLL,      8'h01, 1'b0, NOT_TYPED},
        '{MODE_EXCHANGE, CMD_POLL,      8'h7E, 1'b0, NOT_TYPED},
        '{MODE_EXCHANGE, CMD_POLL,      8'h80, 1'b0, NOT_TYPED},
        '{MODE_EXCHANGE, CMD_POLL,      8'h00, 1'b0, NOT_TYPED}
    };

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic       i_mode = MODE_START;
    logic [2:0] i_command_index = CMD_POLL;
    logic [7:0] i_rx_byte = 8'h00;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic       o_kind;
    logic [7:0] o_tx_byte;
    logic       o_select_active;
    logic [7:0] o_packet_byte;
    logic [5:0] o_packet_index;
    logic       o_last;
    logic       o_status;

    psx_pad_poll_sequencer_unit #(
        .PARAM_LEN (PAD_PARAM_LEN),
        .DATA_MAX  (PAD_DATA_MAX)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_command_index (i_command_index),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_tx_byte       (o_tx_byte),
        .o_select_active (o_select_active),
        .o_packet_byte   (o_packet_byte),
        .o_packet_index  (o_packet_index),
        .o_last          (o_last),
        .o_status        (o_status)
    );

    // 20 ns period.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Predicted pad sequencer state, updated once per accepted input transaction.
    logic [7:0]   pad_store [STORE_DEPTH];
    int           pad_byte_cnt = 0;
    int           pad_data_cnt = 0;
    logic [2:0]   pad_cmd = CMD_POLL;
    logic         pad_busy = 1'b0;
    poll_result_t step_results [STORE_DEPTH];
    int           step_n;

    poll_result_t awaited_pad_results [$];
    int           fail_count = 0;

    // Idle and stall odds in percent per cycle, set by the stimulus phases.
    int gap_pct = 0;
    int stall_pct = 0;
    // Hold-off handshake between stimulus and receiver: bump the request to start one.
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    function automatic logic [7:0] reverse_bits(input logic [7:0] v);
        return {<<{v}};
    endfunction

    function automatic void emit(input logic kind, input logic [7:0] tx, input logic sel,
                                 input logic [7:0] pb, input int pi, input logic last,
                                 input logic status);
        step_results[step_n] = '{kind, tx, sel, pb, 6'(pi), last, status};
        step_n++;
    endfunction

    function automatic logic [7:0] pad_header_byte(input int pos);
        if (pos == 0) return HDR_SYNC_BYTE;
        if (pos == 1) return PAD_CMD_BYTES[pad_cmd];
        return HDR_IDLE_BYTE;
    endfunction

    function automatic logic [7:0] pad_param_byte(input int pos);
        if (pos < PAD_PARAM_LEN && pos < 8) return PAD_PARAMS[pad_cmd][pos];
        return 8'h00;
    endfunction

    // Advance the predicted sequencer by one input transaction; fill step_results.
    function automatic void predict_pad_results(input logic mode, input logic [2:0] cmd,
                                                input logic [7:0] rx);
        int needed;
        step_n = 0;
        if (mode == MODE_START) begin
            if (pad_busy) begin
                emit(KIND_TX, 8'h00, 1'b1, 8'h00, 0, 1'b1, STATUS_REJECT);
            end else if (cmd >= CMD_COUNT) begin
                emit(KIND_TX, 8'h00, 1'b0, 8'h00, 0, 1'b1, STATUS_REJECT);
            end else begin
                pad_cmd = cmd;
                pad_byte_cnt = 0;
                pad_data_cnt = 0;
                pad_busy = 1'b1;
                emit(KIND_TX, reverse_bits(pad_header_byte(0)), 1'b1, 8'h00, 0, 1'b1,
                     STATUS_OK);
            end
            return;
        end
        if (!pad_busy) begin
            emit(KIND_TX, 8'h00, 1'b0, 8'h00, 0, 1'b1, STATUS_REJECT);
            return;
        end
        if (pad_byte_cnt < STORE_DEPTH) pad_store[pad_byte_cnt] = reverse_bits(rx);
        if (pad_byte_cnt >= HEADER_LEN) pad_data_cnt++;
        pad_byte_cnt++;
        if (pad_byte_cnt < HEADER_LEN) begin
            emit(KIND_TX, reverse_bits(pad_header_byte(pad_byte_cnt)), 1'b1, 8'h00, 0, 1'b1,
                 STATUS_OK);
            return;
        end
        // Data length from the mode byte, saturated.
        needed = int'(pad_store[1][3:0]) * 2;
        if (needed > PAD_DATA_MAX) needed = PAD_DATA_MAX;
        if (pad_data_cnt < needed) begin
            emit(KIND_TX, reverse_bits(pad_param_byte(pad_data_cnt)), 1'b1, 8'h00, 0, 1'b1,
                 STATUS_OK);
            return;
        end
        // Poll complete: release select and read out the whole packet.
        pad_busy = 1'b0;
        for (int k = 0; k < pad_byte_cnt && k < STORE_DEPTH; k++) begin
            emit(KIND_PACKET, 8'h00, 1'b0, pad_store[k], k, (k + 1 == pad_byte_cnt),
                 STATUS_OK);
        end
    endfunction

    // Offer one input transaction, hold it until accepted, then log what it should yield.
    task automatic send_item(input logic mode, input logic [2:0] cmd, input logic [7:0] rx,
                             input logic typed, input poll_result_t want);
        // Idle the sender at random; valid drops only when a gap is actually taken.
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_command_index <= cmd;
        i_rx_byte <= rx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_pad_results(mode, cmd, rx);
        if (typed) begin
            awaited_pad_results.push_back(want);
        end else begin
            for (int k = 0; k < step_n; k++) awaited_pad_results.push_back(step_results[k]);
        end
    endtask

    // Random polls: mostly complete polls with random content, some truncated polls,
    // stray items and starts while busy mixed in.
    task automatic run_random_polls(input int item_goal);
        int         sent;
        int         pick;
        int         nib_pick;
        logic [3:0] nib;
        int         data_len;
        int         n_exch;
        logic [2:0] cmd;
        logic [7:0] rx;
        sent = 0;
        while (sent < item_goal) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                // Stray item of any shape.
                send_item(1'($urandom_range(1)), 3'($urandom_range(7)),
                          8'($urandom_range(255)), 1'b0, NOT_TYPED);
                sent++;
            end else begin
                // Finish a dangling poll first so this one starts clean.
                while (pad_busy) begin
                    send_item(MODE_EXCHANGE, CMD_POLL, 8'($urandom_range(255)), 1'b0,
                              NOT_TYPED);
                    sent++;
                end
                cmd = 3'($urandom_range(CMD_COUNT - 1));
                // Bias toward short packets; long ones still reach the full store.
                nib_pick = $urandom_range(99);
                if (nib_pick < 50)      nib = 4'($urandom_range(3));
                else if (nib_pick < 85) nib = 4'($urandom_range(7, 4));
                else                    nib = 4'($urandom_range(15, 8));
                data_len = int'(nib) * 2;
                if (data_len > PAD_DATA_MAX) data_len = PAD_DATA_MAX;
                n_exch = HEADER_LEN + data_len;
                if (pick < 16) n_exch = $urandom_range(n_exch - 1);
                send_item(MODE_START, cmd, 8'($urandom_range(255)), 1'b0, NOT_TYPED);
                sent++;
                for (int i = 0; i < n_exch; i++) begin
                    if ($urandom_range(99) < 4) begin
                        send_item(MODE_START, 3'($urandom_range(7)), 8'($urandom_range(255)),
                                  1'b0, NOT_TYPED);
                        sent++;
                    end
                    // Second exchange carries the mode byte.
                    if (i == 1) rx = reverse_bits({4'h0, nib}) | 8'($urandom_range(15));
                    else        rx = 8'($urandom_range(255));
                    send_item(MODE_EXCHANGE, CMD_POLL, rx, 1'b0, NOT_TYPED);
                    sent++;
                end
            end
        end
    endtask

    // Receiver: random stalls, plus a long hold-off on request so the block backs up.
    always @(posedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare each accepted output transaction with the oldest expectation.
    always @(posedge i_clk) begin
        poll_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_pad_results.size() == 0) begin
                $error("unexpected output transaction: kind %0d tx 0x%0h index %0d",
                       o_kind, o_tx_byte, o_packet_index);
                fail_count++;
            end else begin
                want = awaited_pad_results.pop_front();
                check_field("kind", want.kind, o_kind);
                check_field("tx_byte", want.tx_byte, o_tx_byte);
                check_field("select_active", want.select_active, o_select_active);
                check_field("packet_byte", want.packet_byte, o_packet_byte);
                check_field("packet_index", want.packet_index, o_packet_index);
                check_field("last", want.last, o_last);
                check_field("status", want.status, o_status);
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows, no idling.
        for (int r = 0; r < DIRECTED_N; r++) begin
            send_item(DIRECTED_ROWS[r].mode, DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].rx,
                      DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
        end

        // Full rate, with one long receiver hold-off while the sender keeps offering.
        hold_req++;
        run_random_polls(PHASE_ITEMS);

        gap_pct = 57;
        run_random_polls(PHASE_ITEMS);

        gap_pct = 0;
        stall_pct = 57;
        run_random_polls(PHASE_ITEMS);

        gap_pct = 31;
        stall_pct = 31;
        run_random_polls(PHASE_ITEMS);

        // Drop valid, release the receiver and drain.
        i_in_valid <= 1'b0;
        stall_pct = 0;
        while (awaited_pad_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: a time limit far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* psx_pad_poll_sequencer_unit.f */
sv/psxp_pkg.sv
sv/psxp_store.sv
sv/psx_pad_poll_sequencer_unit.sv
tb/testbench.sv
